/* rtl/assert_macros.svh */
// Assertion macros for the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and ignored while i_rst_n is low.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk and ignored while i_rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/lpd_pkg.sv */
// Types and constants shared by the length-prefixed deframer modules.
package lpd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 3;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 16'd255;

    // Register index as decoded from paddr[2].
    localparam logic REG_MAX_LENGTH = 1'b0;

    // Input kinds.
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_RESYNC = 1'b1;

    // Framing phase.
    typedef enum logic [1:0] {
        HDR_IDLE    = 2'd0,
        HDR_LOW     = 2'd1,
        HDR_PAYLOAD = 2'd2
    } t_hdr_state;

    typedef struct packed {
        logic [LEN_W-1:0]  message_length;
        logic              aborted;
        logic              last_byte;
        logic [BYTE_W-1:0] payload_byte;
    } t_result;

endpackage

/* rtl/lpd_cfg.sv */
// APB configuration register holding the maximum accepted payload length.
module lpd_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lpd_pkg::APB_AW-1:0]   paddr,
    input  logic [lpd_pkg::APB_DW-1:0]   pwdata,
    output logic [lpd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [lpd_pkg::LEN_W-1:0]    o_max_length
);
    import lpd_pkg::*;

    logic [LEN_W-1:0] r_max_length;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
        end else if (wr_en) begin
            r_max_length <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_LENGTH) begin
            prdata = {{(APB_DW-LEN_W){1'b0}}, r_max_length};
        end
    end

    assign o_max_length = r_max_length;

endmodule

/* rtl/lpd_core.sv */
// Input register and framing state: header parse, discard count and payload pass-through.
module lpd_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lpd_pkg::LEN_W-1:0]   i_max_length,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [lpd_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_res_ready,
    output logic                        o_res_valid,
    output lpd_pkg::t_result            o_res
);
    import lpd_pkg::*;

    logic              r_in_valid;
    logic              r_kind;
    logic [BYTE_W-1:0] r_byte;

    t_hdr_state        r_hdr,      n_hdr;
    logic [BYTE_W-1:0] r_low,      n_low;
    logic [LEN_W-1:0]  r_exp_len,  n_exp_len;
    logic [LEN_W-1:0]  r_rcv_cnt,  n_rcv_cnt;
    logic [LEN_W-1:0]  r_discard,  n_discard;

    logic              advance;
    logic [LEN_W-1:0]  hdr_len;
    logic [LEN_W:0]    rcv_next;
    logic              is_last;

    // The item in the input register moves on whenever the result stage can take it.
    assign advance    = r_in_valid && i_res_ready;
    assign o_in_ready = !r_in_valid || i_res_ready;

    assign hdr_len  = {r_byte, r_low};
    assign rcv_next = {1'b0, r_rcv_cnt} + {{LEN_W{1'b0}}, 1'b1};
    assign is_last  = rcv_next >= {1'b0, r_exp_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind <= i_kind;
            r_byte <= i_data_byte;
        end
    end

    // Next framing state.
    always_comb begin
        n_hdr     = r_hdr;
        n_low     = r_low;
        n_exp_len = r_exp_len;
        n_rcv_cnt = r_rcv_cnt;
        n_discard = r_discard;
        if (r_kind == KIND_RESYNC) begin
            n_hdr     = HDR_IDLE;
            n_low     = '0;
            n_exp_len = '0;
            n_rcv_cnt = '0;
            n_discard = '0;
        end else if (r_discard != '0) begin
            n_discard = r_discard - 1'b1;
        end else begin
            unique case (r_hdr)
                HDR_IDLE: begin
                    n_low = r_byte;
                    n_hdr = HDR_LOW;
                end
                HDR_LOW: begin
                    n_hdr = HDR_IDLE;
                    if (hdr_len == '0) begin
                        n_hdr = HDR_IDLE;
                    end else if (hdr_len > i_max_length) begin
                        n_discard = hdr_len;
                    end else begin
                        n_exp_len = hdr_len;
                        n_rcv_cnt = '0;
                        n_hdr     = HDR_PAYLOAD;
                    end
                end
                HDR_PAYLOAD: begin
                    n_rcv_cnt = rcv_next[LEN_W-1:0];
                    if (is_last) begin
                        n_hdr     = HDR_IDLE;
                        n_exp_len = '0;
                        n_rcv_cnt = '0;
                    end
                end
                default: begin
                    n_hdr = HDR_IDLE;
                end
            endcase
        end
    end

    // Result for the current item.
    always_comb begin
        o_res_valid          = 1'b0;
        o_res.payload_byte   = r_byte;
        o_res.last_byte      = is_last;
        o_res.aborted        = 1'b0;
        o_res.message_length = r_exp_len;
        if (r_kind == KIND_RESYNC) begin
            // A resync only reports when part of a message has already gone out.
            o_res_valid        = advance && (r_hdr == HDR_PAYLOAD) && (r_rcv_cnt != '0);
            o_res.payload_byte = '0;
            o_res.last_byte    = 1'b0;
            o_res.aborted      = 1'b1;
        end else if (r_discard == '0 && r_hdr == HDR_PAYLOAD) begin
            o_res_valid = advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr     <= HDR_IDLE;
            r_low     <= '0;
            r_exp_len <= '0;
            r_rcv_cnt <= '0;
            r_discard <= '0;
        end else if (advance) begin
            r_hdr     <= n_hdr;
            r_low     <= n_low;
            r_exp_len <= n_exp_len;
            r_rcv_cnt <= n_rcv_cnt;
            r_discard <= n_discard;
        end
    end

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_abort_in_payload, o_res_valid && o_res.aborted, r_hdr == HDR_PAYLOAD)
    `ASSERT_IMPLIES(a_discard_not_payload, r_discard != '0, r_hdr == HDR_IDLE)
    `ASSERT_NEXT(a_last_ends_message, o_res_valid && o_res.last_byte, r_hdr == HDR_IDLE && r_rcv_cnt == '0)

endmodule

/* rtl/lpd_out.sv */
// Result register feeding the master-side stream.
module lpd_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  lpd_pkg::t_result  i_res,
    output logic              o_res_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output lpd_pkg::t_result  o_res
);
    import lpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register can be loaded when empty or when its transaction completes now.
    assign o_res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/length_prefixed_deframer.sv */
// A byte accepted into the input register moves on to the result register, which drives its result.
// Throughput: one input transaction per cycle, sustained while the output side keeps up;
// the input register and the result register each hold one item, so a stall on the
// output backs up through both stages before the input side stops.
// Reset (synchronous, active low) clears all framing state and restores max_length to 255.
module length_prefixed_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration port. Register 0 (byte address 0) is max_length.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] kind (0 = stream byte, 1 = resync)

    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] message_length
    output logic        m_axis_tlast,   // last_byte
    output logic        m_axis_tuser    // [0] aborted
);
    import lpd_pkg::*;

    logic [LEN_W-1:0] max_length;
    logic             res_valid;
    logic             res_ready;
    t_result          core_res;
    t_result          out_res;

    // The user must write the register block only while the stream is idle (not enforced
    // here), so the framing logic reads max_length directly without any synchronization.
    lpd_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_max_length (max_length)
    );

    // The core registers each input transaction, then from the registered byte
    // parses headers, counts off refused payloads, and forms at most one result.
    lpd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_length (max_length),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_data_byte  (s_axis_tdata),
        .i_res_ready  (res_ready),
        .o_res_valid  (res_valid),
        .o_res        (core_res)
    );

    // The result register decouples the two sides so that a finished byte can
    // wait for the sink while the next input transaction is already taken.
    lpd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (core_res),
        .o_res_ready (res_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {out_res.message_length, out_res.payload_byte};
    assign m_axis_tlast = out_res.last_byte;
    assign m_axis_tuser = out_res.aborted;

endmodule
